// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post, msg) \
	`ASSERT_PROP(lbl, (pre) |=> (post), msg)

`endif

// ----- rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// shared types and constants of the scrambled frame checker
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int MAX_FRAME_BYTES = 256;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

	localparam int BYTE_W    = 8;
	localparam int MAXPL_W   = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLE_KEY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_SEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd4;

	localparam logic [BYTE_W-1:0]  RST_MAGIC_FIRST   = 8'd44;
	localparam logic [BYTE_W-1:0]  RST_MAGIC_SECOND  = 8'd18;
	localparam logic [BYTE_W-1:0]  RST_SCRAMBLE_KEY  = 8'd18;
	localparam logic [BYTE_W-1:0]  RST_CHECKSUM_SEED = 8'hA0;
	localparam logic [MAXPL_W-1:0] RST_MAX_PAYLOAD   = 9'd128;

	localparam logic [POS_W-1:0] POS_MAGIC0   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_MAGIC1   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(7);
	localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(8);
	localparam logic [POS_W-1:0] MIN_FRAME    = POS_W'(9);
	localparam logic [POS_W-1:0] POS_LIMIT    = POS_W'(MAX_FRAME_BYTES);

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_BAD_MAGIC = 3'd2,
		VERDICT_TOO_LONG  = 3'd3,
		VERDICT_CHECKSUM  = 3'd4
	} verdict_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] plain;
		logic [BYTE_W-1:0] index;
		verdict_t          verdict;
		logic              last;
	} result_t;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- rtl/scrambled_frame_checker_core.sv -----
// ----------------------------------------------------------------------------
// scrambled_frame_checker_core
// header check, payload descramble and checksum verdict, one word per unstalled cycle
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in       | sink      | in_valid/in_stall   | frame_byte, end_of_frame
//  out      | source    | out_valid/out_stall | result_kind, plain_byte,
//           |           |                     | payload_index, verdict, last_result
//  cfg      | sink      | cfg_we              | cfg_index, cfg_data
//
//  one input word per cycle; a word yields zero, one or two results
//  results pass through a four-entry result queue and are read from its registered entries
//  input stalls while fewer than two queue entries are free
//  arst_n clears frame state, queue and registers to their defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scrambled_frame_checker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sfc_pkg::BYTE_W-1:0]    frame_byte,
	input  logic                          end_of_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          result_kind,
	output logic [sfc_pkg::BYTE_W-1:0]    plain_byte,
	output logic [sfc_pkg::BYTE_W-1:0]    payload_index,
	output logic [2:0]                    verdict,
	output logic                          last_result,
	input  logic                          cfg_we,
	input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfc_pkg::CFG_W-1:0]     cfg_data
);
	import sfc_pkg::*;

	logic [BYTE_W-1:0]  magic_first_q, magic_second_q, scramble_key_q, checksum_seed_q;
	logic [MAXPL_W-1:0] max_payload_q;

	logic [POS_W-1:0]   pos_q, pos_nxt;
	logic               magic_good_q, magic_good_nxt;
	logic [BYTE_W-1:0]  sent_cks_q, sent_cks_nxt;
	logic [BYTE_W-1:0]  plen_q, plen_nxt;
	logic [BYTE_W-1:0]  xor_q, xor_nxt;

	result_t            fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic               in_acc, pop, in_range, in_payload, emit;
	logic [POS_W-1:0]   idx, len;
	logic [BYTE_W-1:0]  plain;
	logic [POS_W:0]     need_len;
	verdict_t           vcode;
	result_t            res_pay, res_ver, entry0;
	logic [1:0]         push_n;

	assign in_acc = in_valid && !in_stall;
	assign pop    = out_valid && !out_stall;

	// frame tracking
	always_comb begin
		pos_nxt        = pos_q;
		magic_good_nxt = magic_good_q;
		sent_cks_nxt   = sent_cks_q;
		plen_nxt       = plen_q;
		xor_nxt        = xor_q;
		in_range       = pos_q < POS_LIMIT;
		idx            = pos_q - HEADER_BYTES;
		in_payload     = (pos_q >= HEADER_BYTES) && (idx < {{(POS_W-BYTE_W){1'b0}}, plen_q});
		plain          = frame_byte ^ scramble_key_q;
		emit           = 1'b0;
		if (in_range) begin
			case (pos_q)
				POS_MAGIC0: begin
					if (frame_byte != magic_first_q) magic_good_nxt = 1'b0;
				end
				POS_MAGIC1: begin
					if (frame_byte != magic_second_q) magic_good_nxt = 1'b0;
				end
				POS_CHECKSUM: sent_cks_nxt = frame_byte;
				POS_LENGTH:   plen_nxt = frame_byte;
				default: begin
					if (in_payload) begin
						xor_nxt = xor_q ^ plain;
						emit    = magic_good_q &&
							({1'b0, plen_q} < max_payload_q);
					end
				end
			endcase
			pos_nxt = pos_q + POS_W'(1);
		end
		len      = pos_nxt;
		need_len = {1'b0, HEADER_BYTES} + (POS_W+1)'(plen_nxt);
		if (len < MIN_FRAME)
			vcode = VERDICT_SHORT;
		else if (!magic_good_nxt)
			vcode = VERDICT_BAD_MAGIC;
		else if ({1'b0, len} < need_len)
			vcode = VERDICT_SHORT;
		else if ({1'b0, plen_nxt} >= max_payload_q)
			vcode = VERDICT_TOO_LONG;
		else if (sent_cks_nxt != (xor_nxt ^ checksum_seed_q))
			vcode = VERDICT_CHECKSUM;
		else
			vcode = VERDICT_OK;
	end

	always_comb begin
		res_pay         = '0;
		res_pay.kind    = KIND_PAYLOAD;
		res_pay.plain   = plain;
		res_pay.index   = idx[BYTE_W-1:0];
		res_pay.verdict = VERDICT_OK;
		res_ver         = '0;
		res_ver.kind    = KIND_VERDICT;
		res_ver.verdict = vcode;
		res_ver.last    = 1'b1;
		entry0          = emit ? res_pay : res_ver;
		push_n          = in_acc ? ({1'b0, emit} + {1'b0, end_of_frame}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			magic_good_q <= 1'b1;
			sent_cks_q   <= '0;
			plen_q       <= '0;
			xor_q        <= '0;
		end else if (in_acc) begin
			if (end_of_frame) begin
				pos_q        <= '0;
				magic_good_q <= 1'b1;
				sent_cks_q   <= '0;
				plen_q       <= '0;
				xor_q        <= '0;
			end else begin
				pos_q        <= pos_nxt;
				magic_good_q <= magic_good_nxt;
				sent_cks_q   <= sent_cks_nxt;
				plen_q       <= plen_nxt;
				xor_q        <= xor_nxt;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q   <= RST_MAGIC_FIRST;
			magic_second_q  <= RST_MAGIC_SECOND;
			scramble_key_q  <= RST_SCRAMBLE_KEY;
			checksum_seed_q <= RST_CHECKSUM_SEED;
			max_payload_q   <= RST_MAX_PAYLOAD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAGIC_FIRST:   magic_first_q   <= cfg_data[BYTE_W-1:0];
				REG_MAGIC_SECOND:  magic_second_q  <= cfg_data[BYTE_W-1:0];
				REG_SCRAMBLE_KEY:  scramble_key_q  <= cfg_data[BYTE_W-1:0];
				REG_CHECKSUM_SEED: checksum_seed_q <= cfg_data[BYTE_W-1:0];
				REG_MAX_PAYLOAD:   max_payload_q   <= cfg_data[MAXPL_W-1:0];
				default: ;
			endcase
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wr_ptr_q] <= entry0;
		if (push_n == 2'd2) fifo_q[wr_ptr_q + PTR_W'(1)] <= res_ver;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q  <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assign in_stall      = count_q > CNT_W'(FIFO_DEPTH - 2);
	assign out_valid     = count_q != '0;
	assign result_kind   = fifo_q[rd_ptr_q].kind;
	assign plain_byte    = fifo_q[rd_ptr_q].plain;
	assign payload_index = fifo_q[rd_ptr_q].index;
	assign verdict       = fifo_q[rd_ptr_q].verdict;
	assign last_result   = fifo_q[rd_ptr_q].last;

	`ASSERT_PROP(a_count_bound, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`ASSERT_NEXT(a_frame_clear, in_acc && end_of_frame, pos_q == '0 && magic_good_q,
		"frame state not cleared after final word")
	`ASSERT_PROP(a_last_kind, !out_valid || (last_result == result_kind),
		"last flag disagrees with result kind")

endmodule

// ----- test/scrambled_frame_checker_core_test.sv -----
// ----------------------------------------------------------------------------
// scrambled_frame_checker_core_test
// self-checking bench for the frame checker core: a short scripted opening
// at the default settings, then randomly built frames (good, truncated,
// bad magic, oversized, overlong, noise) under a series of register
// settings, with random gaps on the byte side and random stalls on the
// result side; opening verdicts come from its table, other results from a model of the deframer
// ----------------------------------------------------------------------------
module scrambled_frame_checker_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sfc_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              eof;
		logic              typed;
		verdict_t          v;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    frame_byte = '0;
	logic                 end_of_frame = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 result_kind;
	logic [BYTE_W-1:0]    plain_byte;
	logic [BYTE_W-1:0]    payload_index;
	logic [2:0]           verdict;
	logic                 last_result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// register copies
	logic [BYTE_W-1:0]  want_magic0 = RST_MAGIC_FIRST;
	logic [BYTE_W-1:0]  want_magic1 = RST_MAGIC_SECOND;
	logic [BYTE_W-1:0]  key = RST_SCRAMBLE_KEY;
	logic [BYTE_W-1:0]  seed = RST_CHECKSUM_SEED;
	logic [MAXPL_W-1:0] payload_cap = RST_MAX_PAYLOAD;

	// frame tracking
	logic [POS_W-1:0]  frame_pos = '0;
	logic              magic_ok = 1'b1;
	logic [BYTE_W-1:0] sent_sum = '0;
	logic [BYTE_W-1:0] stated_len = '0;
	logic [BYTE_W-1:0] plain_xor = '0;

	result_t  due_results[$];
	int       mismatches = 0;
	int       words_sent = 0;
	bit       no_gaps = 1'b0;
	bit       pin_verdict = 1'b0;
	verdict_t pinned_verdict = VERDICT_OK;

	row_t opening_rows [28] = '{
		'{8'h2C, 1'b1, 1'b1, VERDICT_SHORT},
		'{8'h2C, 1'b0, 1'b0, VERDICT_OK},
		'{8'h12, 1'b0, 1'b0, VERDICT_OK},
		'{8'h4D, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'hFF, 1'b0, 1'b0, VERDICT_OK},
		'{8'h55, 1'b0, 1'b0, VERDICT_OK},
		'{8'hAA, 1'b0, 1'b0, VERDICT_OK},
		'{8'h01, 1'b0, 1'b0, VERDICT_OK},
		'{8'hFF, 1'b1, 1'b1, VERDICT_OK},
		'{8'hFF, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b1, 1'b1, VERDICT_BAD_MAGIC},
		'{8'h2C, 1'b0, 1'b0, VERDICT_OK},
		'{8'h12, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h00, 1'b0, 1'b0, VERDICT_OK},
		'{8'h80, 1'b1, 1'b1, VERDICT_CHECKSUM}
	};

	scrambled_frame_checker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.plain_byte(plain_byte),
		.payload_index(payload_index),
		.verdict(verdict),
		.last_result(last_result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(99) < 28);
	endfunction

	// expected results of one accepted byte
	task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic eof);
		result_t           r;
		logic [POS_W-1:0]  idx;
		logic [BYTE_W-1:0] plain;
		verdict_t          v;
		if (frame_pos < POS_LIMIT) begin
			if (frame_pos == POS_MAGIC0) begin
				if (b != want_magic0) magic_ok = 1'b0;
			end else if (frame_pos == POS_MAGIC1) begin
				if (b != want_magic1) magic_ok = 1'b0;
			end else if (frame_pos == POS_CHECKSUM) begin
				sent_sum = b;
			end else if (frame_pos == POS_LENGTH) begin
				stated_len = b;
			end else if (frame_pos >= HEADER_BYTES) begin
				idx = frame_pos - HEADER_BYTES;
				if (idx < stated_len) begin
					plain = b ^ key;
					plain_xor = plain_xor ^ plain;
					if (magic_ok && stated_len < payload_cap) begin
						r = '{kind: KIND_PAYLOAD, plain: plain, index: idx[BYTE_W-1:0],
							verdict: VERDICT_OK, last: 1'b0};
						due_results.push_back(r);
					end
				end
			end
			frame_pos = frame_pos + POS_W'(1);
		end
		if (eof) begin
			if (frame_pos < MIN_FRAME)
				v = VERDICT_SHORT;
			else if (!magic_ok)
				v = VERDICT_BAD_MAGIC;
			else if (frame_pos < HEADER_BYTES + stated_len)
				v = VERDICT_SHORT;
			else if (stated_len >= payload_cap)
				v = VERDICT_TOO_LONG;
			else if (sent_sum != (plain_xor ^ seed))
				v = VERDICT_CHECKSUM;
			else
				v = VERDICT_OK;
			if (pin_verdict) v = pinned_verdict;
			r = '{kind: KIND_VERDICT, plain: '0, index: '0, verdict: v, last: 1'b1};
			due_results.push_back(r);
			frame_pos = '0;
			magic_ok = 1'b1;
			sent_sum = '0;
			stated_len = '0;
			plain_xor = '0;
		end
	endtask

	// called and returns at a falling edge
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic eof);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		frame_byte <= b;
		end_of_frame <= eof;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		deframe_byte(b, eof);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAGIC_FIRST:   want_magic0 = data[BYTE_W-1:0];
			REG_MAGIC_SECOND:  want_magic1 = data[BYTE_W-1:0];
			REG_SCRAMBLE_KEY:  key = data[BYTE_W-1:0];
			REG_CHECKSUM_SEED: seed = data[BYTE_W-1:0];
			REG_MAX_PAYLOAD:   payload_cap = data[MAXPL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] k,
		input logic [7:0] s, input logic [8:0] cap);
		write_reg(REG_MAGIC_FIRST, {1'b0, m0});
		write_reg(REG_MAGIC_SECOND, {1'b0, m1});
		write_reg(REG_SCRAMBLE_KEY, {1'b0, k});
		write_reg(REG_CHECKSUM_SEED, {1'b0, s});
		write_reg(REG_MAX_PAYLOAD, cap);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_frame();
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] p;
		int unsigned       pick;
		int unsigned       n;
		int unsigned       extra;
		int unsigned       cut;
		pick = $urandom_range(99);
		if (pick < 10) begin
			// noise
			repeat ($urandom_range(12, 1)) body.push_back(8'($urandom_range(255)));
		end else begin
			if (pick >= 97)
				n = $urandom_range(255, 240);
			else if (pick >= 90 && payload_cap <= 255)
				n = $urandom_range(payload_cap + 6 > 255 ? 255 : payload_cap + 6, payload_cap);
			else if ($urandom_range(9) == 0)
				n = $urandom_range(255);
			else
				n = $urandom_range(12);
			sum = '0;
			body.push_back(want_magic0);
			body.push_back(want_magic1);
			body.push_back(8'h00);
			repeat (4) body.push_back(8'($urandom_range(255)));
			body.push_back(n[7:0]);
			repeat (n) begin
				p = 8'($urandom_range(255));
				sum = sum ^ p;
				body.push_back(p ^ key);
			end
			body[2] = sum ^ seed;
			if ($urandom_range(99) < 12) body[2] = body[2] ^ 8'($urandom_range(255, 1));
			// broken magic
			if (pick < 18) body[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
			if (pick >= 97)
				extra = $urandom_range(24);
			else if ($urandom_range(4) == 0)
				extra = $urandom_range(3);
			else
				extra = 0;
			repeat (extra) body.push_back(8'($urandom_range(255)));
			// truncated
			if (pick >= 18 && pick < 30) begin
				cut = $urandom_range(body.size() - 1);
				body = body[0:cut];
			end
		end
		foreach (body[i]) send_word(body[i], i == body.size() - 1);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 28);
	end

	always @(posedge clk) begin
		result_t exp;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result_kind: expected none, got %0d", result_kind);
				mismatches++;
			end else begin
				exp = due_results.pop_front();
				check_field("result_kind", exp.kind, result_kind);
				check_field("plain_byte", exp.plain, plain_byte);
				check_field("payload_index", exp.index, payload_index);
				check_field("verdict", exp.verdict, verdict);
				check_field("last_result", exp.last, last_result);
			end
		end
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int goal;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			pin_verdict = opening_rows[i].typed;
			pinned_verdict = opening_rows[i].v;
			send_word(opening_rows[i].b, opening_rows[i].eof);
			pin_verdict = 1'b0;
		end

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: load_settings(8'h00, 8'hFF, 8'h00, 8'h00, 9'd1);
					2: load_settings(8'hFF, 8'h00, 8'hFF, 8'hFF, 9'd256);
					default: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						$urandom_range(2) == 0 ? 9'($urandom_range(256, 1)) :
							9'($urandom_range(24, 1)));
				endcase
			end
			no_gaps = (ph == 4);
			goal = words_sent + 180;
			while (words_sent < goal) send_frame();
		end
		no_gaps = 1'b0;

		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
